// ----- sv/pccu_pkg.sv -----
package pccu_pkg;

	localparam int MAX_SENSORS_DEF = 8;
	localparam int RING_DEPTH_DEF  = 8;

	localparam logic [2:0] OP_RESET   = 3'd0;
	localparam logic [2:0] OP_STOP    = 3'd1;
	localparam logic [2:0] OP_START   = 3'd2;
	localparam logic [2:0] OP_ADD     = 3'd3;
	localparam logic [2:0] OP_CAPTURE = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_SETUP = 2'd1;
	localparam logic [1:0] MODE_CAPT  = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_CONF   = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	localparam logic [2:0] ST_SUCCESS  = 3'd0;
	localparam logic [2:0] ST_READ_SZ  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTSETUP = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;

	localparam logic [6:0] LEN_START = 7'd6;
	localparam logic [6:0] LEN_ADD   = 7'd14;

	// floor log2 with flog2(0) = 0
	function automatic logic [4:0] flog2(input logic [31:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 1; i < 32; i++)
			if (v[i]) r = 5'(i);
		return r;
	endfunction

	function automatic logic [11:0] conf_of(input logic [31:0] t);
		logic [4:0] l;
		logic [4:0] a;
		logic [2:0] st;
		logic [2:0] av;
		if (t[31]) begin
			st = 3'd3;
			av = 3'd0;
		end else begin
			l  = flog2(t);
			a  = flog2(t >> 3) >> 1;
			st = (l > 5'd7) ? 3'd7 : l[2:0];
			av = (a > 5'd7) ? 3'd7 : a[2:0];
		end
		return {av, st, st, 3'b101};
	endfunction

endpackage

// ----- sv/pccu_ring.sv -----
// Report ring storage: sample memory, per-slot time and size memory.
module pccu_ring #(
	parameter int MAX_SENSORS = pccu_pkg::MAX_SENSORS_DEF,
	parameter int RING_DEPTH  = pccu_pkg::RING_DEPTH_DEF,
	localparam int SW = $clog2(MAX_SENSORS) > 0 ? $clog2(MAX_SENSORS) : 1,
	localparam int RW = $clog2(RING_DEPTH) > 0 ? $clog2(RING_DEPTH) : 1,
	localparam int CW = $clog2(MAX_SENSORS + 1)
) (
	input  logic          clk,
	input  logic          s_we,
	input  logic [RW-1:0] s_wslot,
	input  logic [SW-1:0] s_widx,
	input  logic [15:0]   s_wdata,
	input  logic [RW-1:0] s_rslot,
	input  logic [SW-1:0] s_ridx,
	output logic [15:0]   s_rdata,
	input  logic          t_we,
	input  logic [RW-1:0] t_wslot,
	input  logic [31:0]   t_wdata,
	input  logic          z_we,
	input  logic [CW-1:0] z_wdata,
	input  logic [RW-1:0] m_rslot,
	output logic [31:0]   t_rdata,
	output logic [CW-1:0] z_rdata
);
	logic [15:0]   smem [RING_DEPTH*MAX_SENSORS];
	logic [31:0]   tmem [RING_DEPTH];
	logic [CW-1:0] zmem [RING_DEPTH];

	localparam int AW = RW + SW;
	logic [AW-1:0] wa, ra;
	assign wa = AW'(s_wslot) * AW'(MAX_SENSORS) + AW'(s_widx);
	assign ra = AW'(s_rslot) * AW'(MAX_SENSORS) + AW'(s_ridx);

	always_ff @(posedge clk) begin
		if (s_we) smem[wa] <= s_wdata;
		s_rdata <= smem[ra];
		if (t_we) tmem[t_wslot] <= t_wdata;
		if (z_we) zmem[t_wslot] <= z_wdata;
		t_rdata <= tmem[m_rslot];
		z_rdata <= zmem[m_rslot];
	end
endmodule

// ----- sv/power_capture_command_unit.sv -----
// Power-capture command unit.
// Input channel (in_valid/in_ready): one command word per handshake, fields
// operation .. timestamp. Output channel (out_valid/out_ready): result words
// with kind, status, configuration and report fields; last marks the final
// word of a command. Reset, stop and capture give no word; read on an empty
// ring gives none.
// One command at a time: a command is taken only when the engine is idle.
// Simple commands finish in the execute state. Start walks the sensor list,
// reading each entry and then emitting its configuration word, and ends with
// the status word. Read drains one report: it reads the size, then reads
// each sample word from the sample memory and emits it. Both walks are paced
// by the single registered read port of the sensor-list and ring memories.
// A stalled receiver holds the output register; the walk waits with it.
// arst_n clears mode, count, ring pointers and handshakes; memory contents
// are left undefined until written.
module power_capture_command_unit #(
	parameter int MAX_SENSORS = pccu_pkg::MAX_SENSORS_DEF,
	parameter int RING_DEPTH  = pccu_pkg::RING_DEPTH_DEF,
	localparam int SW = $clog2(MAX_SENSORS) > 0 ? $clog2(MAX_SENSORS) : 1,
	localparam int RW = $clog2(RING_DEPTH) > 0 ? $clog2(RING_DEPTH) : 1,
	localparam int CW = $clog2(MAX_SENSORS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [6:0]  packet_length,
	input  logic signed [31:0] itime_ms,
	input  logic [7:0]  sensor_port,
	input  logic [7:0]  sensor_bus_addr,
	input  logic [2:0]  sensor_index,
	input  logic [15:0] sample_value,
	input  logic [31:0] timestamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  status,
	output logic [7:0]  out_port,
	output logic [8:0]  device_addr,
	output logic [11:0] conf_word,
	output logic [3:0]  report_size,
	output logic [31:0] report_time,
	output logic [15:0] report_sample,
	output logic        last
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_CONF  = 5'b00100,
		S_RHEAD = 5'b01000,
		S_RSAMP = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [RW-1:0] head_q, tail_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] sz_q;
	logic [11:0]   conf_q;

	// latched command
	logic [2:0]  op_q;
	logic [6:0]  len_q;
	logic [31:0] tm_q;
	logic [7:0]  port_q, baddr_q;
	logic [2:0]  sidx_q;
	logic [15:0] samp_q;
	logic [31:0] stamp_q;

	// sensor list memories
	logic [7:0] lport [MAX_SENSORS];
	logic [8:0] laddr [MAX_SENSORS];
	logic [7:0] lport_rd;
	logic [8:0] laddr_rd;
	logic       l_we;
	logic [SW-1:0] l_wa, l_ra;

	logic       pend_s1;   // a read issued last cycle is valid now
	logic       obusy;
	assign obusy = out_valid && !out_ready;
	assign in_ready = (state_q == S_IDLE);

	// ring
	logic          s_we, t_we, z_we;
	logic [15:0]   s_rdata;
	logic [31:0]   t_rdata;
	logic [CW-1:0] z_rdata;
	logic [RW-1:0] headp1, tailp1;
	assign headp1 = (32'(head_q) == RING_DEPTH - 1) ? '0 : head_q + 1'b1;
	assign tailp1 = (32'(tail_q) == RING_DEPTH - 1) ? '0 : tail_q + 1'b1;

	logic cap_ok;
	assign cap_ok = (mode_q == pccu_pkg::MODE_CAPT) && (CW'(sidx_q) < count_q)
		&& (32'(sidx_q) < MAX_SENSORS);
	assign s_we = (state_q == S_EXEC) && (op_q == pccu_pkg::OP_CAPTURE) && cap_ok;
	assign t_we = s_we && (sidx_q == 3'd0);
	assign z_we = s_we && (CW'(sidx_q) + 1'b1 == count_q);

	pccu_ring #(.MAX_SENSORS(MAX_SENSORS), .RING_DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .s_we(s_we), .s_wslot(head_q), .s_widx(SW'(sidx_q)),
		.s_wdata(samp_q), .s_rslot(tail_q), .s_ridx(idx_q[SW-1:0]),
		.s_rdata(s_rdata), .t_we(t_we), .t_wslot(head_q), .t_wdata(stamp_q),
		.z_we(z_we), .z_wdata(count_q), .m_rslot(tail_q),
		.t_rdata(t_rdata), .z_rdata(z_rdata)
	);

	logic add_ok;
	assign add_ok = (state_q == S_EXEC) && (op_q == pccu_pkg::OP_ADD)
		&& (mode_q == pccu_pkg::MODE_OFF || mode_q == pccu_pkg::MODE_SETUP)
		&& (len_q == pccu_pkg::LEN_ADD) && (32'(count_q) < MAX_SENSORS);
	assign l_we = add_ok;
	assign l_wa = (mode_q == pccu_pkg::MODE_OFF) ? '0 : count_q[SW-1:0];
	assign l_ra = idx_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (l_we) begin
			lport[l_wa] <= port_q;
			laddr[l_wa] <= {baddr_q, 1'b0};
		end
		lport_rd <= lport[l_ra];
		laddr_rd <= laddr[l_ra];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= operation; len_q <= packet_length; tm_q <= itime_ms;
			port_q <= sensor_port; baddr_q <= sensor_bus_addr;
			sidx_q <= sensor_index; samp_q <= sample_value; stamp_q <= timestamp;
		end
	end

	task automatic put_status(input logic [2:0] st);
		out_valid <= 1'b1; kind <= pccu_pkg::KIND_STATUS; status <= st;
		out_port <= '0; device_addr <= '0; conf_word <= '0; report_size <= '0;
		report_time <= '0; report_sample <= '0; last <= 1'b1;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; mode_q <= pccu_pkg::MODE_OFF; count_q <= '0;
			head_q <= '0; tail_q <= '0; idx_q <= '0; sz_q <= '0;
			conf_q <= '0; pend_s1 <= 1'b0; out_valid <= 1'b0;
			kind <= '0; status <= '0; out_port <= '0; device_addr <= '0;
			conf_word <= '0; report_size <= '0; report_time <= '0;
			report_sample <= '0; last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					// wait for a free output register before any reply
					if (!obusy) begin
						idx_q <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_IDLE;
						case (op_q)
							pccu_pkg::OP_RESET: begin
								mode_q <= pccu_pkg::MODE_OFF;
								head_q <= '0; tail_q <= '0;
							end
							pccu_pkg::OP_STOP: begin
								if (mode_q == pccu_pkg::MODE_CAPT) begin
									mode_q <= pccu_pkg::MODE_SETUP;
									head_q <= '0; tail_q <= '0;
								end
							end
							pccu_pkg::OP_START: begin
								if (mode_q != pccu_pkg::MODE_SETUP)
									put_status(pccu_pkg::ST_NOTSETUP);
								else if (len_q != pccu_pkg::LEN_START)
									put_status(pccu_pkg::ST_READ_SZ);
								else if (tm_q == 32'd0)
									put_status(pccu_pkg::ST_UNKNOWN);
								else begin
									conf_q <= pccu_pkg::conf_of(tm_q);
									mode_q <= pccu_pkg::MODE_CAPT;
									state_q <= S_CONF;
								end
							end
							pccu_pkg::OP_ADD: begin
								if (!(mode_q == pccu_pkg::MODE_OFF ||
								      mode_q == pccu_pkg::MODE_SETUP))
									put_status(pccu_pkg::ST_NOTSETUP);
								else if (len_q != pccu_pkg::LEN_ADD)
									put_status(pccu_pkg::ST_READ_SZ);
								else if (32'(count_q) >= MAX_SENSORS)
									put_status(pccu_pkg::ST_FULL);
								else begin
									mode_q <= pccu_pkg::MODE_SETUP;
									count_q <= (mode_q == pccu_pkg::MODE_OFF) ?
										CW'(1) : count_q + 1'b1;
									put_status(pccu_pkg::ST_SUCCESS);
								end
							end
							pccu_pkg::OP_CAPTURE: begin
								if (z_we) begin
									if (headp1 == tail_q) tail_q <= tailp1;
									head_q <= headp1;
								end
							end
							pccu_pkg::OP_READ: begin
								if (head_q != tail_q) state_q <= S_RHEAD;
							end
							default: put_status(pccu_pkg::ST_UNKNOWN);
						endcase
					end
				end
				S_CONF: begin
					// memory read of idx_q lands next cycle; emit then advance
					if (!pend_s1) begin
						pend_s1 <= 1'b1;
					end else if (!obusy) begin
						if (idx_q >= count_q) begin
							put_status(pccu_pkg::ST_SUCCESS);
							state_q <= S_IDLE;
						end else begin
							out_valid <= 1'b1; kind <= pccu_pkg::KIND_CONF;
							status <= '0; out_port <= lport_rd;
							device_addr <= laddr_rd; conf_word <= conf_q;
							report_size <= '0; report_time <= '0;
							report_sample <= '0; last <= 1'b0;
							idx_q <= idx_q + 1'b1;
							pend_s1 <= 1'b0;
						end
					end
				end
				S_RHEAD: begin
					if (!pend_s1) begin
						pend_s1 <= 1'b1;
					end else begin
						sz_q <= (32'(z_rdata) > MAX_SENSORS) ? CW'(MAX_SENSORS) : z_rdata;
						pend_s1 <= 1'b0;
						state_q <= S_RSAMP;
					end
				end
				S_RSAMP: begin
					if (!pend_s1) begin
						pend_s1 <= 1'b1;
					end else if (!obusy) begin
						out_valid <= 1'b1; kind <= pccu_pkg::KIND_REPORT;
						status <= '0; out_port <= '0; device_addr <= '0;
						conf_word <= '0; report_size <= 4'(sz_q);
						report_time <= t_rdata;
						report_sample <= (sz_q == '0) ? 16'd0 : s_rdata;
						pend_s1 <= 1'b0;
						if (sz_q == '0 || idx_q + 1'b1 == sz_q) begin
							last <= 1'b1;
							tail_q <= tailp1;
							state_q <= S_IDLE;
						end else begin
							last <= 1'b0;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
